[sv/touch_sample_average_calibrate_top_assert.svh]
// ----------------------------------------------------------------------------
// Touch sample averaging: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_AVERAGE_CALIBRATE_TOP_ASSERT_SVH
`define TOUCH_SAMPLE_AVERAGE_CALIBRATE_TOP_ASSERT_SVH

// same-cycle implication
`define TSAC_ASSERT_SAME(label, clk, en, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(en)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSAC_ASSERT_NEXT(label, clk, en, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(en)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tsac_pkg.sv]
// ----------------------------------------------------------------------------
// Touch sample averaging: package
// Widths, register map, state and command types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsac_pkg;

  localparam int TSAC_RAW_W   = 16;
  localparam int TSAC_SUM_W   = 24;
  localparam int TSAC_CNT_W   = 8;
  localparam int TSAC_COORD_W = 12;
  localparam int TSAC_DIV_W   = 28;
  localparam int TSAC_ADDR_W  = 5;

  localparam logic [2:0] REG_MIN_RAW_X = 3'd0;
  localparam logic [2:0] REG_MAX_RAW_X = 3'd1;
  localparam logic [2:0] REG_MIN_RAW_Y = 3'd2;
  localparam logic [2:0] REG_MAX_RAW_Y = 3'd3;
  localparam logic [2:0] REG_SCALE_X   = 3'd4;
  localparam logic [2:0] REG_SCALE_Y   = 3'd5;

  typedef enum logic {
    DIV_MAP_X,
    DIV_MAP_Y
  } div_sel_t;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } axis_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_FIRST,
    ST_AVG_SECOND,
    ST_X_CLAMP,
    ST_X_MUL,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_CLAMP,
    ST_Y_MUL,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_EMIT
  } tsac_state_t;

  typedef struct packed {
    logic [TSAC_RAW_W-1:0]   min_raw_x;
    logic [TSAC_RAW_W-1:0]   max_raw_x;
    logic [TSAC_RAW_W-1:0]   min_raw_y;
    logic [TSAC_RAW_W-1:0]   max_raw_y;
    logic [TSAC_COORD_W-1:0] scale_x;
    logic [TSAC_COORD_W-1:0] scale_y;
  } tsac_cfg_t;

  typedef struct packed {
    logic     acc_sample;
    logic     clr_batch;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_avg_first;
    logic     cap_avg_second;
    axis_t    axis;
    logic     cap_diff;
    logic     cap_prod;
    logic     cap_cx;
    logic     cap_cy;
    logic     set_abort;
    logic     load_out;
  } tsac_cmd_t;

  typedef struct packed {
    logic taken_zero;
    logic last_sample;
    logic div_done;
    logic out_blocked;
  } tsac_status_t;

endpackage

`default_nettype wire

[sv/tsac_div.sv]
// ----------------------------------------------------------------------------
// Touch sample averaging: iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsac_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [tsac_pkg::TSAC_DIV_W-1:0] dividend,
  input  wire logic [tsac_pkg::TSAC_RAW_W-1:0] divisor,
  output logic                                done,
  output logic      [tsac_pkg::TSAC_DIV_W-1:0] quotient
);
  import tsac_pkg::*;

  localparam int CntW = $clog2(TSAC_DIV_W);

  logic [TSAC_DIV_W-1:0] dvd_r;
  logic [TSAC_RAW_W-1:0] dsr_r;
  logic [TSAC_RAW_W-1:0] rem_r;
  logic [CntW-1:0]       cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [TSAC_RAW_W:0]   trial;
  logic                  fits;

  always_comb begin
    trial = {rem_r, dvd_r[TSAC_DIV_W-1]};
    fits  = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(TSAC_DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[TSAC_DIV_W-2:0], fits};
      rem_r <= fits ? TSAC_RAW_W'(trial - {1'b0, dsr_r}) : trial[TSAC_RAW_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

[sv/tsac_datapath.sv]
// ----------------------------------------------------------------------------
// Touch sample averaging: datapath
// Batch sums, averaging, clamp and scale, calibration divide, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsac_datapath #(
  parameter int BATCH_SAMPLES = 50
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tsac_pkg::tsac_cfg_t               cfg,
  input  wire tsac_pkg::tsac_cmd_t               cmd,
  output tsac_pkg::tsac_status_t                 status,
  input  wire logic [tsac_pkg::TSAC_RAW_W-1:0]   in_sample_x,
  input  wire logic [tsac_pkg::TSAC_RAW_W-1:0]   in_sample_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_valid_res,
  output logic      [tsac_pkg::TSAC_COORD_W-1:0] out_coord_x,
  output logic      [tsac_pkg::TSAC_COORD_W-1:0] out_coord_y
);
  import tsac_pkg::*;

  localparam logic [TSAC_CNT_W-1:0] BatchLast = TSAC_CNT_W'(BATCH_SAMPLES - 1);

  // average = (sum * ceil(2^AvgShift / BATCH)) >> AvgShift, exact for 24-bit sums
  localparam int AvgShift = TSAC_SUM_W + $clog2(BATCH_SAMPLES);
  localparam int RecipW   = TSAC_SUM_W + 1;
  localparam int AvgProdW = TSAC_SUM_W + RecipW;
  localparam logic [RecipW-1:0] AvgRecip =
    RecipW'(((64'd1 << AvgShift) + 64'(BATCH_SAMPLES) - 64'd1) / 64'(BATCH_SAMPLES));

  logic [TSAC_SUM_W-1:0]   sum_first_r;
  logic [TSAC_SUM_W-1:0]   sum_second_r;
  logic [TSAC_CNT_W-1:0]   taken_r;
  logic [TSAC_RAW_W-1:0]   avg_first_r;
  logic [TSAC_RAW_W-1:0]   avg_second_r;
  logic [TSAC_RAW_W-1:0]   diff_r;
  logic [TSAC_DIV_W-1:0]   prod_r;
  logic                    res_valid_r;
  logic [TSAC_COORD_W-1:0] res_cx_r;
  logic [TSAC_COORD_W-1:0] res_cy_r;
  logic                    out_valid_r;
  logic                    out_valid_res_r;
  logic [TSAC_COORD_W-1:0] out_cx_r;
  logic [TSAC_COORD_W-1:0] out_cy_r;

  logic [TSAC_SUM_W-1:0]   avg_src;
  logic [AvgProdW-1:0]     avg_prod;
  logic [TSAC_RAW_W-1:0]   avg_quot;
  logic [TSAC_DIV_W-1:0]   div_dvd;
  logic [TSAC_RAW_W-1:0]   div_dsr;
  logic                    div_done;
  logic [TSAC_DIV_W-1:0]   div_quot;
  logic [TSAC_RAW_W-1:0]   ax_avg;
  logic [TSAC_RAW_W-1:0]   ax_lo;
  logic [TSAC_RAW_W-1:0]   ax_hi;
  logic [TSAC_COORD_W-1:0] ax_scale;
  logic [TSAC_RAW_W-1:0]   clamped;
  logic                    ok_x;
  logic                    ok_y;

  assign ok_x = (cfg.max_raw_x > cfg.min_raw_x);
  assign ok_y = (cfg.max_raw_y > cfg.min_raw_y);

  always_comb begin
    avg_src  = cmd.cap_avg_second ? sum_second_r : sum_first_r;
    avg_prod = {{RecipW{1'b0}}, avg_src} * {{TSAC_SUM_W{1'b0}}, AvgRecip};
    avg_quot = avg_prod[AvgShift +: TSAC_RAW_W];
  end

  always_comb begin
    if (cmd.axis == AXIS_X) begin
      ax_avg   = avg_second_r;
      ax_lo    = cfg.min_raw_x;
      ax_hi    = cfg.max_raw_x;
      ax_scale = cfg.scale_x;
    end else begin
      ax_avg   = avg_first_r;
      ax_lo    = cfg.min_raw_y;
      ax_hi    = cfg.max_raw_y;
      ax_scale = cfg.scale_y;
    end
    if (ax_avg < ax_lo) begin
      clamped = ax_lo;
    end else if (ax_avg > ax_hi) begin
      clamped = ax_hi;
    end else begin
      clamped = ax_avg;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_MAP_X: begin
        div_dvd = prod_r;
        div_dsr = cfg.max_raw_x - cfg.min_raw_x;
      end
      DIV_MAP_Y: begin
        div_dvd = prod_r;
        div_dsr = cfg.max_raw_y - cfg.min_raw_y;
      end
      default: begin
        div_dvd = prod_r;
        div_dsr = '0;
      end
    endcase
  end

  tsac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quot)
  );

  // batch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_first_r  <= '0;
      sum_second_r <= '0;
      taken_r      <= '0;
    end else if (cmd.clr_batch) begin
      sum_first_r  <= '0;
      sum_second_r <= '0;
      taken_r      <= '0;
    end else if (cmd.acc_sample) begin
      sum_first_r  <= sum_first_r + TSAC_SUM_W'(in_sample_x);
      sum_second_r <= sum_second_r + TSAC_SUM_W'(in_sample_y);
      taken_r      <= taken_r + 1'b1;
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.cap_avg_first) begin
      avg_first_r <= avg_quot;
    end
    if (cmd.cap_avg_second) begin
      avg_second_r <= avg_quot;
    end
    if (cmd.cap_diff) begin
      diff_r <= clamped - ax_lo;
    end
    if (cmd.cap_prod) begin
      prod_r <= {{(TSAC_DIV_W-TSAC_RAW_W){1'b0}}, diff_r} *
                {{(TSAC_DIV_W-TSAC_COORD_W){1'b0}}, ax_scale};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_abort) begin
      res_valid_r <= 1'b0;
      res_cx_r    <= '0;
      res_cy_r    <= '0;
    end else begin
      if (cmd.cap_cx) begin
        res_valid_r <= 1'b1;
        res_cx_r    <= ok_x ? div_quot[TSAC_COORD_W-1:0] : '0;
      end
      if (cmd.cap_cy) begin
        res_cy_r <= ok_y ? (cfg.scale_y - div_quot[TSAC_COORD_W-1:0]) : '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_valid_res_r <= res_valid_r;
      out_cx_r        <= res_cx_r;
      out_cy_r        <= res_cy_r;
    end
  end

  always_comb begin
    status.taken_zero  = (taken_r == '0);
    status.last_sample = (taken_r == BatchLast);
    status.div_done    = div_done;
    status.out_blocked = out_valid_r && out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_valid_res_r;
  assign out_coord_x   = out_cx_r;
  assign out_coord_y   = out_cy_r;

endmodule

`default_nettype wire

[sv/tsac_ctrl.sv]
// ----------------------------------------------------------------------------
// Touch sample averaging: controller
// Sequences sample accumulation, batch-end divides and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tsac_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_pressed,
  output logic                        in_stall,
  input  wire tsac_pkg::tsac_status_t status,
  output tsac_pkg::tsac_cmd_t         cmd
);
  import tsac_pkg::*;

  tsac_state_t state_r;
  tsac_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.axis  = AXIS_X;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_pressed) begin
            cmd.acc_sample = 1'b1;
            if (status.last_sample) begin
              state_nxt = ST_AVG_FIRST;
            end
          end else if (!status.taken_zero) begin
            cmd.clr_batch = 1'b1;
            cmd.set_abort = 1'b1;
            state_nxt     = ST_EMIT;
          end
        end
      end
      ST_AVG_FIRST: begin
        cmd.cap_avg_first = 1'b1;
        state_nxt         = ST_AVG_SECOND;
      end
      ST_AVG_SECOND: begin
        cmd.cap_avg_second = 1'b1;
        cmd.clr_batch      = 1'b1;
        state_nxt          = ST_X_CLAMP;
      end
      ST_X_CLAMP: begin
        cmd.cap_diff = 1'b1;
        state_nxt    = ST_X_MUL;
      end
      ST_X_MUL: begin
        cmd.cap_prod = 1'b1;
        state_nxt    = ST_X_GO;
      end
      ST_X_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MAP_X;
        state_nxt     = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        if (status.div_done) begin
          cmd.cap_cx = 1'b1;
          state_nxt  = ST_Y_CLAMP;
        end
      end
      ST_Y_CLAMP: begin
        cmd.axis     = AXIS_Y;
        cmd.cap_diff = 1'b1;
        state_nxt    = ST_Y_MUL;
      end
      ST_Y_MUL: begin
        cmd.axis     = AXIS_Y;
        cmd.cap_prod = 1'b1;
        state_nxt    = ST_Y_GO;
      end
      ST_Y_GO: begin
        cmd.axis      = AXIS_Y;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MAP_Y;
        state_nxt     = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        cmd.axis = AXIS_Y;
        if (status.div_done) begin
          cmd.cap_cy = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.out_blocked) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/touch_sample_average_calibrate_top.sv]
// A sample that does not close a batch is taken without a stall.
// A batch-closing sample raises out_valid after two
// reciprocal-multiply averages, two bit-serial calibration divides and the
// clamp, multiply and hand-off steps. An aborting release goes straight to hand-off.
// Throughput: one sample per cycle inside a batch; input stalls while a batch
// closes and while a new result waits behind a stalled one. Sync reset, low.
// ----------------------------------------------------------------------------
// Touch sample averaging with linear calibration: top level
// APB register file, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_sample_average_calibrate_top #(
  parameter int BATCH_SAMPLES = 50
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_pressed,
  input  wire logic [tsac_pkg::TSAC_RAW_W-1:0]    in_sample_x,
  input  wire logic [tsac_pkg::TSAC_RAW_W-1:0]    in_sample_y,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_valid_res,
  output logic      [tsac_pkg::TSAC_COORD_W-1:0]  out_coord_x,
  output logic      [tsac_pkg::TSAC_COORD_W-1:0]  out_coord_y,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tsac_pkg::TSAC_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready
);
  import tsac_pkg::*;

  tsac_cfg_t    cfg_r;
  tsac_cmd_t    cmd;
  tsac_status_t status;
  logic [2:0]   reg_idx;
  logic         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_raw_x <= 16'd1500;
      cfg_r.max_raw_x <= 16'd31000;
      cfg_r.min_raw_y <= 16'd3276;
      cfg_r.max_raw_y <= 16'd30110;
      cfg_r.scale_x   <= 12'd240;
      cfg_r.scale_y   <= 12'd320;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_RAW_X: cfg_r.min_raw_x <= pwdata[TSAC_RAW_W-1:0];
        REG_MAX_RAW_X: cfg_r.max_raw_x <= pwdata[TSAC_RAW_W-1:0];
        REG_MIN_RAW_Y: cfg_r.min_raw_y <= pwdata[TSAC_RAW_W-1:0];
        REG_MAX_RAW_Y: cfg_r.max_raw_y <= pwdata[TSAC_RAW_W-1:0];
        REG_SCALE_X:   cfg_r.scale_x   <= pwdata[TSAC_COORD_W-1:0];
        REG_SCALE_Y:   cfg_r.scale_y   <= pwdata[TSAC_COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_RAW_X: prdata = 32'(cfg_r.min_raw_x);
      REG_MAX_RAW_X: prdata = 32'(cfg_r.max_raw_x);
      REG_MIN_RAW_Y: prdata = 32'(cfg_r.min_raw_y);
      REG_MAX_RAW_Y: prdata = 32'(cfg_r.max_raw_y);
      REG_SCALE_X:   prdata = 32'(cfg_r.scale_x);
      REG_SCALE_Y:   prdata = 32'(cfg_r.scale_y);
      default:       prdata = '0;
    endcase
  end

  tsac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_pressed (in_pressed),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  tsac_datapath #(
    .BATCH_SAMPLES (BATCH_SAMPLES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .status        (status),
    .in_sample_x   (in_sample_x),
    .in_sample_y   (in_sample_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_coord_x   (out_coord_x),
    .out_coord_y   (out_coord_y)
  );

endmodule

`default_nettype wire

[sv/tsac_checker.sv]
// ----------------------------------------------------------------------------
// Touch sample averaging: port checker
// Result channel checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "touch_sample_average_calibrate_top_assert.svh"

module tsac_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              out_valid_res,
  input wire logic [tsac_pkg::TSAC_COORD_W-1:0] out_coord_x,
  input wire logic [tsac_pkg::TSAC_COORD_W-1:0] out_coord_y
);
  import tsac_pkg::*;

  `TSAC_ASSERT_SAME(a_abort_zero, clk, rst_n, out_valid && !out_valid_res, out_coord_x == '0 && out_coord_y == '0, "aborted transaction carries a coordinate")
  `TSAC_ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, !out_valid, "result pending after reset")
  `TSAC_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid, "stalled result dropped")
  `TSAC_ASSERT_NEXT(a_hold_data, clk, rst_n, out_valid && out_stall, $stable(out_valid_res) && $stable(out_coord_x) && $stable(out_coord_y), "stalled result changed")

endmodule

bind touch_sample_average_calibrate_top tsac_checker u_tsac_checker (.*);

`default_nettype wire

[verif/tsac_coord_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch sample averaging: coordinate checker
// Watches the sample, result and register ports, keeps its own running sums
// and calibration, and compares every result transaction field by field with
// the oldest predicted coordinate pair.
// ----------------------------------------------------------------------------
module tsac_coord_checker #(
  parameter int BATCH = 50
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_pressed,
  input  logic [tsac_pkg::TSAC_RAW_W-1:0]   in_sample_x,
  input  logic [tsac_pkg::TSAC_RAW_W-1:0]   in_sample_y,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              out_valid_res,
  input  logic [tsac_pkg::TSAC_COORD_W-1:0] out_coord_x,
  input  logic [tsac_pkg::TSAC_COORD_W-1:0] out_coord_y,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [tsac_pkg::TSAC_ADDR_W-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output int unsigned                       mismatches,
  output int unsigned                       pending,
  output int unsigned                       results_seen,
  output int unsigned                       coords_seen
);
  import tsac_pkg::*;

  typedef struct packed {
    logic                    valid_res;
    logic [TSAC_COORD_W-1:0] coord_x;
    logic [TSAC_COORD_W-1:0] coord_y;
  } coord_t;

  coord_t                  coords_due[$];
  tsac_cfg_t               cal;
  logic [TSAC_SUM_W-1:0]   acc_x;
  logic [TSAC_SUM_W-1:0]   acc_y;
  logic [TSAC_CNT_W-1:0]   n_taken;
  int unsigned             n_bad;
  int unsigned             n_res;
  int unsigned             n_coord;

  // clamp to [lo, hi], then scale; empty span maps to zero
  function automatic logic [TSAC_COORD_W-1:0] calibrate_axis(
    input logic [TSAC_RAW_W-1:0]   avg,
    input logic [TSAC_RAW_W-1:0]   lo,
    input logic [TSAC_RAW_W-1:0]   hi,
    input logic [TSAC_COORD_W-1:0] scale
  );
    logic [TSAC_RAW_W-1:0] v;
    logic [31:0]           prod;
    if (hi <= lo) return '0;
    v = (avg < lo) ? lo : ((avg > hi) ? hi : avg);
    prod = 32'(v - lo) * 32'(scale);
    return TSAC_COORD_W'(prod / 32'(hi - lo));
  endfunction

  function automatic void predict_sample(
    input logic                  pressed,
    input logic [TSAC_RAW_W-1:0] sx,
    input logic [TSAC_RAW_W-1:0] sy
  );
    logic [TSAC_RAW_W-1:0]   avg_first;
    logic [TSAC_RAW_W-1:0]   avg_second;
    logic [TSAC_COORD_W-1:0] cx;
    logic [TSAC_COORD_W-1:0] vy;
    logic [TSAC_COORD_W-1:0] cy;
    if (!pressed) begin
      if (n_taken != 0) begin
        acc_x = '0;
        acc_y = '0;
        n_taken = '0;
        coords_due.push_back('{1'b0, '0, '0});
      end
      return;
    end
    acc_x = acc_x + TSAC_SUM_W'(sx);
    acc_y = acc_y + TSAC_SUM_W'(sy);
    n_taken = n_taken + 1'b1;
    if (n_taken < TSAC_CNT_W'(BATCH)) return;
    avg_first = TSAC_RAW_W'(acc_x / BATCH);
    avg_second = TSAC_RAW_W'(acc_y / BATCH);
    acc_x = '0;
    acc_y = '0;
    n_taken = '0;
    cx = calibrate_axis(avg_second, cal.min_raw_x, cal.max_raw_x, cal.scale_x);
    vy = calibrate_axis(avg_first, cal.min_raw_y, cal.max_raw_y, cal.scale_y);
    cy = (cal.max_raw_y > cal.min_raw_y) ? cal.scale_y - vy : '0;
    coords_due.push_back('{1'b1, cx, cy});
  endfunction

  always @(posedge clk) begin : monitor
    coord_t got;
    coord_t want;
    if (!rst_n) begin
      cal.min_raw_x = 16'd1500;
      cal.max_raw_x = 16'd31000;
      cal.min_raw_y = 16'd3276;
      cal.max_raw_y = 16'd30110;
      cal.scale_x = 12'd240;
      cal.scale_y = 12'd320;
      acc_x = '0;
      acc_y = '0;
      n_taken = '0;
      n_bad = 0;
      n_res = 0;
      n_coord = 0;
      coords_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MIN_RAW_X: cal.min_raw_x = pwdata[TSAC_RAW_W-1:0];
          REG_MAX_RAW_X: cal.max_raw_x = pwdata[TSAC_RAW_W-1:0];
          REG_MIN_RAW_Y: cal.min_raw_y = pwdata[TSAC_RAW_W-1:0];
          REG_MAX_RAW_Y: cal.max_raw_y = pwdata[TSAC_RAW_W-1:0];
          REG_SCALE_X:   cal.scale_x = pwdata[TSAC_COORD_W-1:0];
          REG_SCALE_Y:   cal.scale_y = pwdata[TSAC_COORD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_sample(in_pressed, in_sample_x, in_sample_y);
      if (out_valid && !out_stall) begin
        got = '{out_valid_res, out_coord_x, out_coord_y};
        n_res++;
        if (got.valid_res === 1'b1) n_coord++;
        if (coords_due.size() == 0) begin
          $error("result transaction with nothing expected: valid_res %0b coord_x %0d coord_y %0d",
                 got.valid_res, got.coord_x, got.coord_y);
          n_bad++;
        end else begin
          want = coords_due.pop_front();
          if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
            n_bad++;
          end
          if (got.coord_x !== want.coord_x) begin
            $error("coord_x: expected %0d, got %0d", want.coord_x, got.coord_x);
            n_bad++;
          end
          if (got.coord_y !== want.coord_y) begin
            $error("coord_y: expected %0d, got %0d", want.coord_y, got.coord_y);
            n_bad++;
          end
        end
      end
    end
    mismatches <= n_bad;
    pending <= coords_due.size();
    results_seen <= n_res;
    coords_seen <= n_coord;
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch sample averaging: testbench top
// Drives touch samples in batches (full, aborted by release, ragged) with
// random content and levels, reprograms the calibration window between
// phases, varies idling on both channels and checks via the coordinate
// checker.
// ----------------------------------------------------------------------------
module tb;
  import tsac_pkg::*;

  localparam int BATCH        = 50;
  localparam int PHASE_ITEMS  = 230;
  localparam int MIN_RESULTS  = 60;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES  = 600;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_pressed = 1'b0;
  logic [TSAC_RAW_W-1:0]   in_sample_x = '0;
  logic [TSAC_RAW_W-1:0]   in_sample_y = '0;
  logic                    out_stall = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [TSAC_ADDR_W-1:0]  paddr = '0;
  logic [31:0]             pwdata = '0;
  wire                     in_stall;
  wire                     out_valid;
  wire                     out_valid_res;
  wire [TSAC_COORD_W-1:0]  out_coord_x;
  wire [TSAC_COORD_W-1:0]  out_coord_y;
  wire [31:0]              prdata;
  wire                     pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned coords_seen;
  int unsigned tx_idle = 27;
  int unsigned rx_idle = 84;
  int unsigned hold_reqs = 0;
  int unsigned items_sent = 0;
  int unsigned batch_fill = 0;
  int unsigned settings_used = 1;

  touch_sample_average_calibrate_top #(.BATCH_SAMPLES(BATCH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pressed(in_pressed),
    .in_sample_x(in_sample_x), .in_sample_y(in_sample_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_valid_res(out_valid_res),
    .out_coord_x(out_coord_x), .out_coord_y(out_coord_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tsac_coord_checker #(.BATCH(BATCH)) coord_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pressed(in_pressed),
    .in_sample_x(in_sample_x), .in_sample_y(in_sample_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_valid_res(out_valid_res),
    .out_coord_x(out_coord_x), .out_coord_y(out_coord_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .pending(pending),
    .results_seen(results_seen), .coords_seen(coords_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $error("timeout with %0d results outstanding", pending);
    $display("touch_sample_average_calibrate_top: mismatch");
    $finish;
  end

  // result side: random stall, or a long hold-off on request
  initial begin : result_side
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle);
      end
    end
  end

  task automatic send_sample(input logic pressed, input logic [TSAC_RAW_W-1:0] sx,
                             input logic [TSAC_RAW_W-1:0] sy);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pressed <= pressed;
    in_sample_x <= sx;
    in_sample_y <= sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (pressed) begin
      items_sent++;
      batch_fill = (batch_fill + 1 == BATCH) ? 0 : batch_fill + 1;
    end else if (batch_fill != 0) begin
      items_sent++;
      batch_fill = 0;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_calibration(input int unsigned minx, input int unsigned maxx,
                                 input int unsigned miny, input int unsigned maxy,
                                 input int unsigned scx, input int unsigned scy);
    drain();
    cfg_write(REG_MIN_RAW_X, minx);
    cfg_write(REG_MAX_RAW_X, maxx);
    cfg_write(REG_MIN_RAW_Y, miny);
    cfg_write(REG_MAX_RAW_Y, maxy);
    cfg_write(REG_SCALE_X, scx);
    cfg_write(REG_SCALE_Y, scy);
    settings_used++;
  endtask

  function automatic logic [TSAC_RAW_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return TSAC_RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [TSAC_RAW_W-1:0] jitter(input logic [TSAC_RAW_W-1:0] base,
                                                    input int unsigned spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return TSAC_RAW_W'(v);
  endfunction

  task automatic run_batch(input int unsigned len, input bit release_after);
    logic [TSAC_RAW_W-1:0] base_x;
    logic [TSAC_RAW_W-1:0] base_y;
    int unsigned           spread;
    bit                    uniform;
    base_x = pick_level();
    base_y = pick_level();
    uniform = ($urandom_range(0, 2) == 0);
    spread = $urandom_range(0, 1) ? 300 : 0;
    repeat (len) begin
      if (uniform) send_sample(1'b1, TSAC_RAW_W'($urandom), TSAC_RAW_W'($urandom));
      else send_sample(1'b1, jitter(base_x, spread), jitter(base_y, spread));
    end
    if (release_after) send_sample(1'b0, TSAC_RAW_W'($urandom), TSAC_RAW_W'($urandom));
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70) run_batch(BATCH - batch_fill, 1'b0);
      else if (r < 88) run_batch($urandom_range(1, BATCH - 1), 1'b1);
      else if (r < 94) send_sample(1'b0, TSAC_RAW_W'($urandom), TSAC_RAW_W'($urandom));
      else run_batch($urandom_range(1, 2 * BATCH), $urandom_range(0, 1));
    end
  endtask

  initial begin : stimulus
    int unsigned lo;
    int unsigned hi;
    int unsigned v;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle releases, aborted batches, field extremes
    send_sample(1'b0, 16'h0000, 16'h0000);
    send_sample(1'b0, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'h0000, 16'h0000);
    send_sample(1'b1, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'h0000, 16'hFFFF);
    send_sample(1'b1, 16'hFFFF, 16'h0000);
    send_sample(1'b0, 16'h1234, 16'h4321);
    send_sample(1'b0, 16'h0000, 16'h0000);
    send_sample(1'b1, 16'h5555, 16'hAAAA);
    send_sample(1'b1, 16'hAAAA, 16'h5555);
    send_sample(1'b0, 16'h0000, 16'h0000);
    send_sample(1'b1, 16'h7FFF, 16'h8000);
    send_sample(1'b0, 16'hFFFF, 16'h0000);

    run_traffic(PHASE_ITEMS);
    set_calibration(0, 65535, 0, 65535, 4095, 4095);
    run_traffic(PHASE_ITEMS);

    tx_idle = 84;
    rx_idle <= 27;
    lo = $urandom_range(20000, 30000);
    v = $urandom_range(15000, 35000);
    set_calibration(lo, lo + $urandom_range(1, 2000), v, v + $urandom_range(1, 2000),
                    $urandom_range(1, 4095), $urandom_range(1, 4095));
    run_traffic(PHASE_ITEMS);
    v = $urandom_range(0, 65535);
    set_calibration(v, v, $urandom_range(30000, 65535), $urandom_range(0, 29999),
                    $urandom_range(1, 4095), $urandom_range(1, 4095));
    run_traffic(PHASE_ITEMS);

    tx_idle = 0;
    rx_idle <= 0;
    set_calibration(1, 65534, 100, 60000, 0, 4095);
    hold_reqs <= hold_reqs + 1;
    run_batch(6 * BATCH, 1'b0);
    run_traffic(PHASE_ITEMS - 6 * BATCH / 2);
    set_calibration(0, 1, 65534, 65535, 1, 0);
    run_traffic(PHASE_ITEMS);
    lo = $urandom_range(0, 65535);
    hi = $urandom_range(0, 65535);
    set_calibration(lo, hi, $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(1, 4095), $urandom_range(1, 4095));
    run_traffic(PHASE_ITEMS);
    while (results_seen < MIN_RESULTS) run_batch(BATCH - batch_fill, 1'b0);

    drain();
    $display("%0d samples over %0d calibration settings; %0d results checked",
             items_sent, settings_used, results_seen);
    $display("(%0d coordinates, %0d release aborts)", coords_seen, results_seen - coords_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("touch_sample_average_calibrate_top: match");
    end else begin
      $display("touch_sample_average_calibrate_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/tsac_pkg.sv
sv/tsac_div.sv
sv/tsac_datapath.sv
sv/tsac_ctrl.sv
sv/touch_sample_average_calibrate_top.sv
sv/tsac_checker.sv
verif/tsac_coord_checker.sv
verif/tb.sv
